FILE: design/cpa_pkg.sv
// Shared constants for the chained page allocator.
package cpa_pkg;
  localparam int NUM_PAGES  = 1024;
  localparam int MAX_ALLOCS = 16;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = PAGE_W + 1;
  localparam int SLOT_W     = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int PNUM_W     = 20;
  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 23;
  localparam int CNT_W      = 11;
  localparam int NEED_W     = 12;
  localparam int PAGE_SHIFT = 12;
  localparam int ENTRY_W    = LINK_W + 1;

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_PAGES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
endpackage

FILE: design/cpa_ifs.sv
// Channel interfaces: request, response and configuration write.
interface cpa_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [22:0] byte_count;
  logic [31:0] free_address;
  modport source (output valid, cmd, byte_count, free_address, input ready);
  modport sink (input valid, cmd, byte_count, free_address, output ready);
endinterface

interface cpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] base_address;
  logic [10:0] page_count;
  logic        tracked;
  modport source (output valid, status, base_address, page_count, tracked, input ready);
  modport sink (input valid, status, base_address, page_count, tracked, output ready);
endinterface

interface cpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: design/chained_page_allocator_unit.sv
// Top level of the chained page allocator: sequencer, page RAM and allocation table.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | cmd, byte_count, free_address
//  rsp     | out | valid/ready | status, base_address, page_count, tracked
//  cfg     | in  | valid/ready | data (region_start_page), always ready
//
// Allocate: one pass over the free bits to count, a second pass to take and link,
// each one page per cycle through the page RAM read port.
// Free: each page of the chain is read from the RAM, then written back as free.
// Zero size, oversize and unknown base go straight to the response; no space costs
// the full counting pass. After reset a clearing pass over all 1024 pages marks every
// page free; req.ready stays low during it. A new request is taken while a response
// waits in the output register; the result is held until rsp is taken.
module chained_page_allocator_unit (
  input logic        clk,
  input logic        rst,
  cpa_req_if.sink    req,
  cpa_rsp_if.source  rsp,
  cpa_cfg_if.sink    cfg
);
  import cpa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_TAKE, S_LAST, S_WRD, S_WWR, S_RESP
  } state_t;

  state_t state;

  logic [PNUM_W-1:0] region;
  logic [LINK_W-1:0] scan_idx;
  logic [PAGE_W-1:0] ex_idx;
  logic              rd_pend;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  got;
  logic [PAGE_W-1:0] prev;
  logic [PAGE_W-1:0] base_rel;
  logic [PNUM_W-1:0] walk_idx;
  logic [CNT_W-1:0]  cnt;

  logic [1:0]        res_status;
  logic [PNUM_W-1:0] res_page;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_trk;

  // Base page of the free request, held for the response
  logic [PNUM_W-1:0] req_page_hold;

  logic              tbl_valid [MAX_ALLOCS];
  logic [PNUM_W-1:0] tbl_page [MAX_ALLOCS];

  logic               ram_we;
  logic [PAGE_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [PAGE_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               rd_free;
  logic [LINK_W-1:0]  rd_link;

  logic [NEED_W-1:0] need_in;
  logic [PNUM_W-1:0] req_page;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              has_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [NEED_W-1:0] got_inc;
  logic              scan_more;

  // Entry layout: {free, link}
  cpa_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_free = ram_rdata[LINK_W];
  assign rd_link = ram_rdata[LINK_W-1:0];

  assign need_in = NEED_W'(req.byte_count[BYTES_W-1:PAGE_SHIFT])
                 + NEED_W'(req.byte_count[PAGE_SHIFT-1:0] != '0);
  assign req_page  = req.free_address[ADDR_W-1:PAGE_SHIFT];
  assign got_inc   = NEED_W'(got) + NEED_W'(1);
  assign scan_more = scan_idx < LINK_END;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Lowest matching slot and lowest empty slot
  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    has_slot  = 1'b0;
    free_slot = '0;
    for (int i = MAX_ALLOCS - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_page[i] == req_page) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!tbl_valid[i]) begin
        has_slot  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx[PAGE_W-1:0];
    ram_wdata = '0;
    ram_raddr = scan_idx[PAGE_W-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, LINK_END};
      end
      S_TAKE: begin
        // link the previous page to this one and mark it taken
        if (rd_pend && rd_free && got != '0) begin
          ram_we    = 1'b1;
          ram_waddr = prev;
          ram_wdata = {1'b0, 1'b0, ex_idx};
        end
      end
      S_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = prev;
        ram_wdata = {1'b0, LINK_END};
      end
      S_WRD: begin
        ram_raddr = walk_idx[PAGE_W-1:0];
      end
      S_WWR: begin
        ram_we    = 1'b1;
        ram_waddr = walk_idx[PAGE_W-1:0];
        ram_wdata = {1'b1, rd_link};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      region    <= '0;
      rsp.valid <= 1'b0;
      for (int i = 0; i < MAX_ALLOCS; i++) begin
        tbl_valid[i] <= 1'b0;
      end
    end else begin
      if (cfg.valid) begin
        region <= cfg.data;
      end
      if (rsp.valid && rsp.ready && state != S_RESP) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          scan_idx <= scan_idx + LINK_W'(1);
          if (scan_idx == LINK_W'(NUM_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            res_status <= (req.cmd == CMD_ALLOC || hit) ? ST_NO_SPACE : ST_NOT_FOUND;
            res_page   <= '0;
            res_cnt    <= '0;
            res_trk    <= 1'b0;
            scan_idx   <= '0;
            got        <= '0;
            rd_pend    <= 1'b0;
            need       <= need_in;
            cnt        <= '0;
            walk_idx   <= req_page - region;
            if (req.cmd == CMD_ALLOC) begin
              if (need_in == '0 || need_in > NEED_W'(NUM_PAGES)) begin
                state <= S_RESP;
              end else begin
                state <= S_CHECK;
              end
            end else if (hit) begin
              tbl_valid[hit_slot] <= 1'b0;
              state <= S_WRD;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_CHECK: begin
          ex_idx <= scan_idx[PAGE_W-1:0];
          if (rd_pend && rd_free && got_inc == need) begin
            // enough pages exist: rescan and take them
            state    <= S_TAKE;
            scan_idx <= '0;
            got      <= '0;
            rd_pend  <= 1'b0;
          end else begin
            rd_pend <= scan_more;
            if (scan_more) begin
              scan_idx <= scan_idx + LINK_W'(1);
            end
            if (rd_pend && rd_free) begin
              got <= got + CNT_W'(1);
            end
            if (rd_pend && ex_idx == PAGE_W'(NUM_PAGES - 1)) begin
              state <= S_RESP;
            end
          end
        end
        S_TAKE: begin
          rd_pend <= scan_more;
          ex_idx  <= scan_idx[PAGE_W-1:0];
          if (scan_more) begin
            scan_idx <= scan_idx + LINK_W'(1);
          end
          if (rd_pend && rd_free) begin
            got  <= got + CNT_W'(1);
            prev <= ex_idx;
            if (got == '0) begin
              base_rel <= ex_idx;
            end
            if (got_inc == need) begin
              state <= S_LAST;
            end
          end
        end
        S_LAST: begin
          if (has_slot) begin
            tbl_valid[free_slot] <= 1'b1;
            tbl_page[free_slot]  <= region + PNUM_W'(base_rel);
          end
          res_status <= ST_OK;
          res_page   <= region + PNUM_W'(base_rel);
          res_cnt    <= need[CNT_W-1:0];
          res_trk    <= has_slot;
          state      <= S_RESP;
        end
        S_WRD: begin
          if (walk_idx >= PNUM_W'(NUM_PAGES) || cnt == CNT_W'(NUM_PAGES)) begin
            res_status <= ST_OK;
            res_page   <= req_page_hold;
            res_cnt    <= cnt;
            res_trk    <= 1'b1;
            state      <= S_RESP;
          end else begin
            state <= S_WWR;
          end
        end
        S_WWR: begin
          cnt      <= cnt + CNT_W'(1);
          walk_idx <= PNUM_W'(rd_link);
          state    <= S_WRD;
        end
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.base_address <= {res_page, {PAGE_SHIFT{1'b0}}};
            rsp.page_count   <= res_cnt;
            rsp.tracked      <= res_trk;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      req_page_hold <= req_page;
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("page RAM written while idle");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.page_count == '0 && rsp.base_address == '0)
    else $error("failed response carries data");

  a_got_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK || state == S_TAKE |-> NEED_W'(got) < need)
    else $error("scan took more pages than requested");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !req.ready)
    else $error("request taken before clearing pass");
endmodule

FILE: design/cpa_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: verif/testbench.sv
// Testbench for the chained page allocator: random and directed requests checked by a scoreboard.
`timescale 1ns / 1ps

import cpa_pkg::*;

typedef struct {
  logic [1:0]  status;
  logic [31:0] base_address;
  logic [10:0] page_count;
  logic        tracked;
} alloc_result_t;

class alloc_scoreboard;
  bit              page_free [NUM_PAGES];
  logic [LINK_W-1:0] next_page [NUM_PAGES];
  bit              slot_valid [MAX_ALLOCS];
  bit [PNUM_W-1:0] slot_page [MAX_ALLOCS];
  bit [PNUM_W-1:0] region_start;
  alloc_result_t   pending_results [$];
  int              errors;
  int              n_alloc_ok, n_alloc_fail, n_untracked, n_free_ok, n_free_miss;

  function new();
    foreach (page_free[i]) page_free[i] = 1'b1;
    foreach (next_page[i]) next_page[i] = '0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    region_start = '0;
  endfunction

  function void set_region(bit [PNUM_W-1:0] start_page);
    region_start = start_page;
  endfunction

  // Allocation: first free pages in index order, linked into a chain.
  function alloc_result_t predict_alloc(bit [BYTES_W-1:0] bytes);
    alloc_result_t r;
    int need;
    int taken [$];
    bit [PNUM_W-1:0] base;
    r = '{ST_NO_SPACE, '0, '0, 1'b0};
    need = (bytes >> PAGE_SHIFT) + ((bytes[11:0] != 0) ? 1 : 0);
    if (need == 0 || need > NUM_PAGES) return r;
    for (int i = 0; i < NUM_PAGES && taken.size() < need; i++)
      if (page_free[i]) taken.push_back(i);
    if (taken.size() < need) return r;
    for (int i = 0; i < need; i++) begin
      page_free[taken[i]] = 1'b0;
      next_page[taken[i]] = (i + 1 < need) ? LINK_W'(taken[i+1]) : LINK_END;
    end
    base = region_start + PNUM_W'(taken[0]);
    r = '{ST_OK, {base, 12'h000}, CNT_W'(need), 1'b0};
    for (int s = 0; s < MAX_ALLOCS; s++)
      if (!slot_valid[s]) begin
        slot_valid[s] = 1'b1;
        slot_page[s] = base;
        r.tracked = 1'b1;
        break;
      end
    return r;
  endfunction

  // Free: lowest matching slot, then walk the chain back into the free map.
  function alloc_result_t predict_free(bit [ADDR_W-1:0] addr);
    alloc_result_t r;
    bit [PNUM_W-1:0] page;
    bit [PNUM_W-1:0] rel;
    int idx;
    int cnt;
    bit hit;
    page = addr[31:12];
    hit = 1'b0;
    cnt = 0;
    for (int s = 0; s < MAX_ALLOCS; s++)
      if (slot_valid[s] && slot_page[s] == page) begin
        slot_valid[s] = 1'b0;
        hit = 1'b1;
        break;
      end
    if (!hit) return '{ST_NOT_FOUND, '0, '0, 1'b0};
    rel = page - region_start;
    idx = rel;
    while (idx < NUM_PAGES && cnt < NUM_PAGES) begin
      page_free[idx] = 1'b1;
      cnt++;
      idx = next_page[idx];
    end
    return '{ST_OK, {page, 12'h000}, CNT_W'(cnt), 1'b1};
  endfunction

  function void note_request(logic cmd, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    if (cmd == CMD_ALLOC) begin
      r = predict_alloc(bytes);
      if (r.status == ST_OK) n_alloc_ok++; else n_alloc_fail++;
      if (r.status == ST_OK && !r.tracked) n_untracked++;
    end else begin
      r = predict_free(addr);
      if (r.status == ST_OK) n_free_ok++; else n_free_miss++;
    end
    pending_results.push_back(r);
  endfunction

  function void check_response(alloc_result_t got);
    alloc_result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("unexpected response status=%0d base=%h", got.status, got.base_address);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.base_address !== exp_r.base_address) begin
      $error("base_address: expected %h, got %h", exp_r.base_address, got.base_address);
      errors++;
    end
    if (got.page_count !== exp_r.page_count) begin
      $error("page_count: expected %0d, got %0d", exp_r.page_count, got.page_count);
      errors++;
    end
    if (got.tracked !== exp_r.tracked) begin
      $error("tracked: expected %0d, got %0d", exp_r.tracked, got.tracked);
      errors++;
    end
  endfunction

  // Random live base, or -1 when the table is empty.
  function int pick_live_base();
    int live [$];
    for (int s = 0; s < MAX_ALLOCS; s++)
      if (slot_valid[s]) live.push_back(slot_page[s]);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  cpa_req_if req_ch ();
  cpa_rsp_if rsp_ch ();
  cpa_cfg_if cfg_ch ();

  alloc_scoreboard sb;
  int idle_cycles;
  int burst_left;
  int stall_mode;
  bit [PNUM_W-1:0] regions [5] = '{20'h00000, 20'hFFFFF, 20'hFFE00, 20'h00000, 20'h00000};

  chained_page_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch accepted transactions on every channel.
  always @(posedge clk) begin
    alloc_result_t got;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.status, rsp_ch.base_address, rsp_ch.page_count, rsp_ch.tracked};
        sb.check_response(got);
      end
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.cmd, req_ch.byte_count, req_ch.free_address);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_region(cfg_ch.data);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("chained_page_allocator_unit: mismatch");
        $finish;
      end
    end
  end

  // Receiver: alternate between stretches of random stalls and always-ready.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_request(logic cmd, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.byte_count <= bytes;
    req_ch.free_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Free every tracked allocation so a region change cannot strand a chain.
  task automatic release_all();
    int b;
    wait_drained();
    b = sb.pick_live_base();
    while (b >= 0) begin
      send_request(CMD_FREE, '0, {b[19:0], 12'($urandom)});
      wait_drained();
      b = sb.pick_live_base();
    end
  endtask

  task automatic write_region(bit [PNUM_W-1:0] start_page);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= start_page;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int b;
    int r;
    logic [BYTES_W-1:0] bytes;
    r = $urandom_range(0, 99);
    b = sb.pick_live_base();
    if (r < 45 || b < 0) begin
      if (r < 3) bytes = BYTES_W'($urandom);
      else if (r < 5) bytes = 23'd0;
      else if (r < 8) bytes = BYTES_W'($urandom_range(65, 300) * 4096 - $urandom_range(0, 4095));
      else bytes = BYTES_W'($urandom_range(1, 6 * 4096));
      send_request(CMD_ALLOC, bytes, $urandom);
    end else if (r < 88) begin
      send_request(CMD_FREE, BYTES_W'($urandom), {b[19:0], 12'($urandom)});
    end else begin
      send_request(CMD_FREE, BYTES_W'($urandom), $urandom);
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_ALLOC;
    req_ch.byte_count <= '0;
    req_ch.free_address <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_region(20'h00000);

    // Directed: whole region, zero size, oversize, offsets, non-contiguous chain.
    send_request(CMD_ALLOC, 23'd4194304, '0);
    send_request(CMD_ALLOC, 23'd1, '0);
    send_request(CMD_FREE, '0, 32'h0000_0FFF);
    send_request(CMD_ALLOC, 23'd0, '0);
    send_request(CMD_ALLOC, 23'h7FFFFF, '0);
    send_request(CMD_ALLOC, 23'd1, '0);
    send_request(CMD_ALLOC, 23'd4097, '0);
    send_request(CMD_ALLOC, 23'd4096, '0);
    send_request(CMD_FREE, '0, 32'h0000_1ABC);
    send_request(CMD_FREE, '0, 32'h0000_1000);
    send_request(CMD_ALLOC, 23'd12288, '0);
    send_request(CMD_FREE, '0, 32'hFFFF_FFFF);
    // Overfill the allocation table: the last one is untracked.
    repeat (14) send_request(CMD_ALLOC, 23'd1, '0);

    for (int ph = 0; ph < 5; ph++) begin
      release_all();
      write_region((ph == 3) ? PNUM_W'($urandom) : regions[ph]);
      for (int n = 0; n < 100; n++) begin
        random_request();
        if (n == 50) wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected responses never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("covered %0d good and %0d failed allocations (%0d untracked), %0d frees, %0d misses",
             sb.n_alloc_ok, sb.n_alloc_fail, sb.n_untracked, sb.n_free_ok, sb.n_free_miss);
    $display("over five region settings including both extremes and wrapping bases");
    if (sb.errors == 0)
      $display("chained_page_allocator_unit: match");
    else
      $display("chained_page_allocator_unit: mismatch");
    $finish;
  end
endmodule
